[hdl/b64e_pkg.sv]
package b64e_pkg;

   // One six-bit group of the encoded stream.
   typedef logic [5:0] sextet_type;

   // Number of characters a complete group of three bytes yields.
   localparam int unsigned GROUP_CHARS = 4;

   // Index of the last character of a group: 1, 2 or 3.
   typedef logic [$clog2(GROUP_CHARS)-1:0] char_idx_type;

   // A packed group of sextets ready for serialization.
   typedef struct packed {
      sextet_type [GROUP_CHARS-1:0] sextets;
      char_idx_type                 last_idx;
   } group_type;

   // Last-character indices of the three ways a group can close.
   localparam char_idx_type LAST_IDX_FULL = 2'd3;
   localparam char_idx_type LAST_IDX_TWO  = 2'd2;
   localparam char_idx_type LAST_IDX_ONE  = 2'd1;

   // Alphabet boundaries and ASCII offsets.
   localparam logic [7:0] UPPER_END   = 8'd26;
   localparam logic [7:0] LOWER_END   = 8'd52;
   localparam logic [7:0] DIGIT_END   = 8'd62;
   localparam logic [7:0] UPPER_BASE  = 8'h41;
   localparam logic [7:0] LOWER_BASE  = 8'h47;
   localparam logic [7:0] DIGIT_SHIFT = 8'd4;
   localparam logic [7:0] CHAR_PLUS   = 8'h2b;
   localparam logic [7:0] CHAR_SLASH  = 8'h2f;
   localparam sextet_type SEXTET_PLUS = 6'd62;

   // Maps a sextet to its character in the standard alphabet.
   function automatic logic [7:0] b64_char(input sextet_type s);
      logic [7:0] w;
      w = {2'b00, s};
      if (w < UPPER_END) begin
         return UPPER_BASE + w;
      end else if (w < LOWER_END) begin
         return LOWER_BASE + w;
      end else if (w < DIGIT_END) begin
         return w - DIGIT_SHIFT;
      end else if (s == SEXTET_PLUS) begin
         return CHAR_PLUS;
      end else begin
         return CHAR_SLASH;
      end
   endfunction

endpackage

[hdl/b64e_stream_if.sv]
// Byte channel into the encoder.
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Character channel out of the encoder.
interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

[hdl/b64e_packer.sv]
module b64e_packer
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req,
   input  logic       grp_free,
   output logic       grp_load,
   output group_type  grp_data
);

   typedef enum logic [1:0] {
      PH_EMPTY,
      PH_ONE,
      PH_TWO
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_first_ff, held_first_in;
   logic [7:0] held_second_ff, held_second_in;
   logic       completes;
   logic       accept;

   // Splits three bytes into four sextets.
   function automatic group_type pack(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input char_idx_type last);
      group_type g;
      g.sextets[0] = b0[7:2];
      g.sextets[1] = {b0[1:0], b1[7:4]};
      g.sextets[2] = {b1[3:0], b2[7:6]};
      g.sextets[3] = b2[5:0];
      g.last_idx   = last;
      return g;
   endfunction

   // A word that closes a group needs the group register; others are only held.
   assign completes = (phase_ff == PH_TWO) || req.final_byte;
   assign req.ready = grp_free || !completes;
   assign accept    = req.valid && req.ready;
   assign grp_load  = accept && completes;

   // Next phase, held bytes and the group formed by this word.
   always_comb begin
      phase_in       = phase_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      case (phase_ff)
         PH_TWO: begin
            grp_data = pack(held_first_ff, held_second_ff, req.data_byte, LAST_IDX_FULL);
            if (accept) begin
               phase_in = PH_EMPTY;
            end
         end
         PH_ONE: begin
            grp_data = pack(held_first_ff, req.data_byte, 8'h00, LAST_IDX_TWO);
            if (accept) begin
               if (req.final_byte) begin
                  phase_in = PH_EMPTY;
               end else begin
                  held_second_in = req.data_byte;
                  phase_in       = PH_TWO;
               end
            end
         end
         default: begin
            grp_data = pack(req.data_byte, 8'h00, 8'h00, LAST_IDX_ONE);
            if (accept) begin
               if (req.final_byte) begin
                  phase_in = PH_EMPTY;
               end else begin
                  held_first_in = req.data_byte;
                  phase_in      = PH_ONE;
               end
            end
         end
      endcase
   end

   // Phase and held bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_EMPTY;
         held_first_ff  <= 8'h00;
         held_second_ff <= 8'h00;
      end else begin
         phase_ff       <= phase_in;
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
      end
   end

endmodule

[hdl/b64e_serializer.sv]
module b64e_serializer
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       grp_load,
   input  group_type  grp_data,
   output logic       grp_free,
   b64e_rsp_if.source rsp
);

   group_type    grp_ff, grp_in;
   logic         grp_valid_ff, grp_valid_in;
   char_idx_type idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   char_ff, char_in;
   logic         last_ff, last_in;
   logic         out_load;
   logic         take;
   logic         grp_done;

   // The output register takes a character whenever it is empty or being drained.
   assign out_load = !rsp_valid_ff || rsp.ready;
   assign take     = grp_valid_ff && out_load;
   assign grp_done = take && (idx_ff == grp_ff.last_idx);
   assign grp_free = !grp_valid_ff || grp_done;

   // Group register and character index.
   always_comb begin
      grp_in       = grp_load ? grp_data : grp_ff;
      grp_valid_in = grp_load ? 1'b1 : (grp_done ? 1'b0 : grp_valid_ff);
      if (grp_load) begin
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   // Output register with the alphabet lookup in front of it.
   always_comb begin
      rsp_valid_in = out_load ? take : rsp_valid_ff;
      char_in      = take ? b64_char(grp_ff.sextets[idx_ff]) : char_ff;
      last_in      = take ? (idx_ff == grp_ff.last_idx) : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      grp_ff  <= grp_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_char  = char_ff;
   assign rsp.last_char = last_ff;

endmodule

[hdl/base64_encoder_unpadded_unit.sv]
// Channel  Direction  Word                         Accepted when
// req      in         data_byte, final_byte        req.valid && req.ready
// rsp      out        out_char, last_char          rsp.valid && rsp.ready
//
// A byte that only joins a group is taken and yields no character.
// A closing byte moves its group to the group register; characters then leave
// one per cycle from the output register while the output is not stalled, and a
// group of three bytes yields four, limited by the single character output port.
// Synchronous reset empties the group, the group register and the output register.
// While the output stalls, bytes that do not close a group are still taken.
module base64_encoder_unpadded_unit
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req,
   b64e_rsp_if.source rsp
);

   logic      grp_load;
   logic      grp_free;
   group_type grp_data;

   // Byte grouping and sextet split.
   b64e_packer u_packer (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .grp_free (grp_free),
      .grp_load (grp_load),
      .grp_data (grp_data)
   );

   // One character per cycle out of the group register while the output is not stalled.
   b64e_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .grp_load (grp_load),
      .grp_data (grp_data),
      .grp_free (grp_free),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   // A group is never loaded over one that still has characters to send.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      grp_load |-> grp_free)
      else $error("group loaded while group register busy");

   // A freshly loaded group has at least two characters, so it is busy next cycle.
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      grp_load |=> !grp_free)
      else $error("group register free right after load");

   // Reset leaves no character on the output.
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("output valid after reset");
`endif

endmodule

[dv/base64_encoder_unpadded_unit_test.sv]
module base64_encoder_unpadded_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import b64e_pkg::*;

   localparam int LONG_HOLD    = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int TIMEOUT_NS   = 2_000_000;

   // Tracks the open byte group and the characters it must produce.
   class char_scoreboard;
      typedef enum logic [1:0] {
         PHASE_EMPTY = 2'd0,
         PHASE_ONE   = 2'd1,
         PHASE_TWO   = 2'd2
      } group_phase_type;

      typedef struct {
         logic [7:0] out_char;
         logic       last_char;
      } char_word_type;

      logic [7:0]      held_first;
      logic [7:0]      held_second;
      group_phase_type group_phase;
      char_word_type   expected_chars[$];
      string           alphabet;
      int              error_count;
      int              bytes_taken;
      int              chars_seen;
      int              groups_closed;

      function new();
         alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         held_first    = '0;
         held_second   = '0;
         group_phase   = PHASE_EMPTY;
         error_count   = 0;
         bytes_taken   = 0;
         chars_seen    = 0;
         groups_closed = 0;
      endfunction

      // Split the three bytes into sextets and queue the first count characters.
      function void close_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int count);
         logic [23:0]   bits;
         char_word_type w;
         int            k;
         bits = {b0, b1, b2};
         for (k = 0; k < count; k++) begin
            w.out_char  = alphabet[bits[23 - 6 * k -: 6]];
            w.last_char = (k == count - 1);
            expected_chars = {expected_chars, w};
         end
         groups_closed++;
         group_phase = PHASE_EMPTY;
      endfunction

      // Note one accepted input word.
      function void note_byte(logic [7:0] b, logic fin);
         bytes_taken++;
         case (group_phase)
            PHASE_TWO: begin
               close_group(held_first, held_second, b, GROUP_CHARS);
            end
            PHASE_ONE: begin
               if (fin) begin
                  close_group(held_first, b, 8'h00, 3);
               end else begin
                  held_second = b;
                  group_phase = PHASE_TWO;
               end
            end
            default: begin
               if (fin) begin
                  close_group(b, 8'h00, 8'h00, 2);
               end else begin
                  held_first  = b;
                  group_phase = PHASE_ONE;
               end
            end
         endcase
      endfunction

      // Compare one result word with the oldest expected word.
      function void check_char(logic [7:0] c, logic l);
         char_word_type w;
         chars_seen++;
         if (expected_chars.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none, actual char %h last %b",
                     $time, c, l);
            return;
         end
         w = expected_chars.pop_front();
         if (w.out_char !== c || w.last_char !== l) begin
            error_count++;
            $display("%0t: mismatch, expected char %h last %b, actual char %h last %b",
                     $time, w.out_char, w.last_char, c, l);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   sender_quiet   = 1'b0;
   bit   receiver_quiet = 1'b0;
   bit   hold_request   = 1'b0;

   char_scoreboard sb = new();

   b64e_req_if req_ch ();
   b64e_rsp_if rsp_ch ();

   base64_encoder_unpadded_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   // Drop valid, then wait out the requested idle time; the payload carries noise meanwhile.
   task automatic idle_sender(input int n);
      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= 8'($urandom);
      req_ch.final_byte <= 1'($urandom);
      repeat (n) @(posedge clock);
   endtask

   // Offer one word, wait for it to be taken, then maybe idle a while.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= b;
      req_ch.final_byte <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_byte(b, fin);
      if (!sender_quiet && $urandom_range(0, 5) == 0) begin
         idle_sender($urandom_range(1, 14));
      end
   endtask

   // Mostly whole messages of random length, with some loose bytes of random flag.
   task automatic send_random(input int count);
      int left;
      int len;
      int i;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 4) == 0) begin
            send_byte(8'($urandom), 1'($urandom));
            left--;
         end else begin
            len = $urandom_range(1, 10);
            if (len > left) len = left;
            for (i = 0; i < len; i++) begin
               send_byte(8'($urandom), i == len - 1);
            end
            left -= len;
         end
      end
   endtask

   // Stop offering until every expected word has come, then let the block settle.
   task automatic drain_results();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (sb.expected_chars.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: check each taken word and stall in random bursts or one long hold.
   initial begin : rsp_side
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_char(rsp_ch.out_char, rsp_ch.last_char);
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!receiver_quiet && $urandom_range(0, 7) == 0) begin
            stall_left   = $urandom_range(1, 14) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Main sequence: reset, directed words, random phases, then the verdict.
   initial begin : req_side
      logic [8:0] directed_words [22] = '{
         9'h100,                         // one-byte message of zero
         9'h1ff,                         // one-byte message of ones
         9'h000, 9'h100,                 // two-byte message of zeros
         9'h0ff, 9'h1ff,                 // two-byte message of ones
         9'h000, 9'h000, 9'h000,         // full group of zeros, no final flag
         9'h0ff, 9'h0ff, 9'h1ff,         // full group of ones, final on the third
         9'h0fb, 9'h0ef, 9'h0be,         // all plus signs
         9'h04d, 9'h061, 9'h16e,         // plain text group
         9'h001, 9'h002, 9'h003, 9'h104  // group then a one-byte tail
      };
      int i;
      int leftover;

      req_ch.valid      = 1'b0;
      req_ch.data_byte  = 8'h00;
      req_ch.final_byte = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 22; i++) begin
         send_byte(directed_words[i][7:0], directed_words[i][8]);
      end
      drain_results();

      send_random(180);

      // Long output hold while bytes keep coming, so the block backs up.
      hold_request = 1'b1;
      send_random(40);
      drain_results();

      send_random(140);

      // Last stretch runs at full rate on both sides.
      sender_quiet   = 1'b1;
      receiver_quiet = 1'b1;
      send_random(60);
      drain_results();

      leftover = sb.expected_chars.size();
      if (leftover != 0) begin
         sb.error_count += leftover;
         $display("%0t: %0d expected words never arrived", $time, leftover);
      end

      $display("Covered %0d bytes closing %0d groups into %0d characters,",
               sb.bytes_taken, sb.groups_closed, sb.chars_seen);
      $display("with random stalls on both sides, a %0d-cycle output hold and drained pauses.",
               LONG_HOLD);
      if (sb.error_count == 0) begin
         $display("base64_encoder_unpadded_unit regression: pass");
      end else begin
         $display("base64_encoder_unpadded_unit regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("%0t: timeout", $time);
      $display("base64_encoder_unpadded_unit regression: fail");
      $finish;
   end

endmodule
